/* hdl/radio_wakeup_handshake_controller_core_defines.svh */
// ----------------------------------------------------------------------------
// Radio wake-up handshake controller: assertion macros
// Shared macros for the concurrent checks of the controller.
// ----------------------------------------------------------------------------
`ifndef RADIO_WAKEUP_HANDSHAKE_CONTROLLER_CORE_DEFINES_SVH
`define RADIO_WAKEUP_HANDSHAKE_CONTROLLER_CORE_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside of reset.
`define RWHC_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rwhc check failed");

// Next-cycle implication, checked on every rising edge outside of reset.
`define RWHC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rwhc check failed");

`endif

/* hdl/rwhc_pkg.sv */
// ----------------------------------------------------------------------------
// Radio wake-up handshake controller package
// Codes, register reset values and the word types shared by the design.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rwhc_pkg;

	// Link phases of the handshake.
	typedef enum logic [3:0] {
		PH_RCV_SLEEP = 4'd0,
		PH_RCV_WAKE  = 4'd1,
		PH_RCV_READY = 4'd2,
		PH_RCV_DATA  = 4'd3,
		PH_RCV_ACK   = 4'd4,
		PH_SND_WAKE  = 4'd5,
		PH_SND_READY = 4'd6,
		PH_SND_DATA  = 4'd7,
		PH_SND_ACK   = 4'd8
	} phase_t;

	// Input word commands.
	typedef enum logic [2:0] {
		CMD_TX_DONE    = 3'd0,
		CMD_RX_FAIL    = 3'd1,
		CMD_RX_DONE    = 3'd2,
		CMD_SLEEP_DONE = 3'd3,
		CMD_SEND       = 3'd4,
		CMD_START      = 3'd5
	} cmd_t;

	// Radio events after packet parsing.
	typedef enum logic [1:0] {
		EV_TX_DONE    = 2'd0,
		EV_RX_FAIL    = 2'd1,
		EV_RX_DONE    = 2'd2,
		EV_SLEEP_DONE = 2'd3
	} ev_t;

	// Radio commands.
	typedef enum logic [1:0] {
		ACT_NONE  = 2'd0,
		ACT_TX    = 2'd1,
		ACT_RX    = 2'd2,
		ACT_SLEEP = 2'd3
	} action_t;

	// Packet types on air.
	typedef enum logic [1:0] {
		PK_WAKE  = 2'd0,
		PK_READY = 2'd1,
		PK_DATA  = 2'd2,
		PK_ACK   = 2'd3
	} pkt_t;

	// Application notices.
	typedef enum logic [1:0] {
		NOTE_NONE  = 2'd0,
		NOTE_RECV  = 2'd1,
		NOTE_ACKED = 2'd2,
		NOTE_FAIL  = 2'd3
	} notice_t;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		REG_OWN_ADDRESS  = 3'd0,
		REG_BCAST_ADDR   = 3'd1,
		REG_WAKE_WINDOW  = 3'd2,
		REG_DATA_WINDOW  = 3'd3,
		REG_SHORT_WINDOW = 3'd4,
		REG_NAP          = 3'd5,
		REG_RETRY_LIMIT  = 3'd6,
		REG_MAX_LENGTH   = 3'd7
	} cfg_idx_t;

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;

	// Reset values of the configuration registers.
	localparam logic [7:0]  RST_OWN_ADDRESS  = 8'd0;
	localparam logic [7:0]  RST_BCAST_ADDR   = 8'd255;
	localparam logic [15:0] RST_WAKE_WINDOW  = 16'd2250;
	localparam logic [15:0] RST_DATA_WINDOW  = 16'd8000;
	localparam logic [15:0] RST_SHORT_WINDOW = 16'd1000;
	localparam logic [15:0] RST_NAP          = 16'd3000;
	localparam logic [3:0]  RST_RETRY_LIMIT  = 4'd10;
	localparam logic [7:0]  RST_MAX_LENGTH   = 8'd252;

	// Configuration register set.
	typedef struct packed {
		logic [7:0]  own_address;
		logic [7:0]  bcast_address;
		logic [15:0] wake_window_ms;
		logic [15:0] data_window_ms;
		logic [15:0] short_window_ms;
		logic [15:0] nap_ms;
		logic [3:0]  wake_retry_limit;
		logic [7:0]  max_message_length;
	} cfg_t;

	// One input word.
	typedef struct packed {
		logic [2:0] cmd;
		logic [7:0] rx_size;
		logic [7:0] rx_head0;
		logic [7:0] rx_head1;
		logic [7:0] rx_head2;
		logic [7:0] req_address;
		logic [7:0] req_length;
	} item_t;

	// One result word.
	typedef struct packed {
		logic [1:0]  radio_action;
		logic [15:0] duration_ms;
		logic [1:0]  pkt_type;
		logic [7:0]  pkt_dest;
		logic [7:0]  pkt_length;
		logic [1:0]  notice;
		logic [7:0]  notice_address;
		logic [7:0]  notice_length;
		logic [3:0]  link_state;
	} result_t;

endpackage

/* hdl/rwhc_evt_if.sv */
// ----------------------------------------------------------------------------
// Event channel interface
// Carries one radio or application event word with a valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface rwhc_evt_if;
	logic       valid;
	logic       ready;
	logic [2:0] cmd;
	logic [7:0] rx_size;
	logic [7:0] rx_head0;
	logic [7:0] rx_head1;
	logic [7:0] rx_head2;
	logic [7:0] req_address;
	logic [7:0] req_length;

	modport source (
		output valid, cmd, rx_size, rx_head0, rx_head1, rx_head2, req_address, req_length,
		input  ready
	);

	modport sink (
		input  valid, cmd, rx_size, rx_head0, rx_head1, rx_head2, req_address, req_length,
		output ready
	);
endinterface

// ----------------------------------------------------------------------------
// Action channel interface
// Carries one radio command and application notice word.
// ----------------------------------------------------------------------------
interface rwhc_act_if;
	logic        valid;
	logic        ready;
	logic [1:0]  radio_action;
	logic [15:0] duration_ms;
	logic [1:0]  pkt_type;
	logic [7:0]  pkt_dest;
	logic [7:0]  pkt_length;
	logic [1:0]  notice;
	logic [7:0]  notice_address;
	logic [7:0]  notice_length;
	logic [3:0]  link_state;

	modport source (
		output valid, radio_action, duration_ms, pkt_type, pkt_dest, pkt_length,
		       notice, notice_address, notice_length, link_state,
		input  ready
	);

	modport sink (
		input  valid, radio_action, duration_ms, pkt_type, pkt_dest, pkt_length,
		       notice, notice_address, notice_length, link_state,
		output ready
	);
endinterface

/* hdl/rwhc_engine.sv */
// ----------------------------------------------------------------------------
// Handshake engine
// Holds the link state and turns one event word into one result word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rwhc_engine
	import rwhc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    fire,
	input  item_t   item,
	input  cfg_t    cfg,
	output result_t res
);

	phase_t     phase_q, phase_d;
	logic [3:0] tries_q, tries_d;
	logic [7:0] pend_dest_q, pend_dest_d;
	logic [7:0] pend_len_q, pend_len_d;
	logic [7:0] in_sender_q, in_sender_d;
	logic [7:0] in_len_q, in_len_d;

	ev_t        ev;
	logic [7:0] ptype;
	logic [7:0] dest;
	logic [7:0] sender;
	logic [7:0] plen;
	logic       send_reject;
	logic [7:0] clip_len;

	// Parse the received header into an event, type, sender and payload length.
	always_comb begin
		ev     = ev_t'(item.cmd[1:0]);
		ptype  = 8'd0;
		dest   = 8'd0;
		sender = 8'd0;
		plen   = 8'd0;
		if (item.cmd == CMD_RX_DONE) begin
			if (item.rx_size == 8'd2) begin
				ev     = EV_RX_DONE;
				dest   = item.rx_head0;
				sender = item.rx_head1;
			end else begin
				ptype  = item.rx_head0;
				dest   = item.rx_head1;
				sender = item.rx_head2;
				if (item.rx_size < 8'd3) begin
					ev = EV_RX_FAIL;
				end else begin
					ev   = EV_RX_DONE;
					plen = item.rx_size - 8'd3;
				end
			end
			if (dest != cfg.own_address && dest != cfg.bcast_address) begin
				ev = EV_RX_FAIL;
			end
		end
	end

	// A send is refused while one is pending, for an empty payload, or mid-receive.
	assign send_reject = (pend_len_q != 8'd0) || (item.req_length == 8'd0) ||
		(phase_q inside {PH_RCV_READY, PH_RCV_DATA, PH_RCV_ACK});

	assign clip_len = (pend_len_q > cfg.max_message_length) ? cfg.max_message_length
		: pend_len_q;

	// Next state.
	always_comb begin
		phase_d     = phase_q;
		tries_d     = tries_q;
		pend_dest_d = pend_dest_q;
		pend_len_d  = pend_len_q;
		in_sender_d = in_sender_q;
		in_len_d    = in_len_q;
		case (item.cmd)
			CMD_SEND: begin
				if (!send_reject) begin
					tries_d     = 4'd0;
					pend_len_d  = item.req_length;
					pend_dest_d = item.req_address;
					phase_d     = PH_SND_WAKE;
				end
			end
			CMD_START: begin
				phase_d = PH_RCV_WAKE;
			end
			CMD_TX_DONE, CMD_RX_FAIL, CMD_RX_DONE, CMD_SLEEP_DONE: begin
				unique case (phase_q)
					PH_RCV_WAKE: begin
						phase_d = (ev == EV_RX_DONE && ptype == {6'd0, PK_WAKE})
							? PH_RCV_READY : PH_RCV_SLEEP;
					end
					PH_RCV_READY: begin
						phase_d = (ev == EV_TX_DONE) ? PH_RCV_DATA : PH_RCV_SLEEP;
					end
					PH_RCV_DATA: begin
						if (ev == EV_RX_DONE && ptype == {6'd0, PK_DATA}) begin
							phase_d     = PH_RCV_ACK;
							in_sender_d = sender;
							in_len_d    = plen;
						end else begin
							phase_d = PH_RCV_SLEEP;
						end
					end
					PH_RCV_ACK: begin
						phase_d = PH_RCV_SLEEP;
					end
					PH_SND_WAKE, PH_SND_DATA: begin
						if (ev == EV_TX_DONE) begin
							phase_d = (phase_q == PH_SND_WAKE) ? PH_SND_READY : PH_SND_ACK;
						end else begin
							phase_d    = PH_RCV_SLEEP;
							pend_len_d = 8'd0;
						end
					end
					PH_SND_READY: begin
						if (ev == EV_RX_DONE && sender == pend_dest_q) begin
							phase_d = PH_SND_DATA;
						end else if (tries_q < cfg.wake_retry_limit) begin
							tries_d = tries_q + 4'd1;
							phase_d = PH_SND_WAKE;
						end else begin
							phase_d    = PH_RCV_SLEEP;
							pend_len_d = 8'd0;
						end
					end
					PH_SND_ACK: begin
						phase_d    = PH_RCV_SLEEP;
						pend_len_d = 8'd0;
					end
					default: begin
						phase_d = PH_RCV_WAKE;
					end
				endcase
			end
			default: ;
		endcase
	end

	// Result word.
	always_comb begin
		res            = '0;
		res.link_state = phase_d;
		case (item.cmd)
			CMD_SEND: begin
				if (send_reject) begin
					res.notice         = NOTE_FAIL;
					res.notice_address = item.req_address;
				end else begin
					res.radio_action = ACT_TX;
					res.pkt_type     = PK_WAKE;
					res.pkt_dest     = item.req_address;
				end
			end
			CMD_START: begin
				res.radio_action = ACT_RX;
				res.duration_ms  = cfg.wake_window_ms;
			end
			CMD_TX_DONE, CMD_RX_FAIL, CMD_RX_DONE, CMD_SLEEP_DONE: begin
				// Going back to sleep is the fallback of every phase but receiver sleep, which opens the wake window.
				res.radio_action = ACT_SLEEP;
				res.duration_ms  = cfg.nap_ms;
				unique case (phase_q)
					PH_RCV_WAKE: begin
						if (ev == EV_RX_DONE && ptype == {6'd0, PK_WAKE}) begin
							res.radio_action = ACT_TX;
							res.duration_ms  = 16'd0;
							res.pkt_type     = PK_READY;
							res.pkt_dest     = sender;
						end
					end
					PH_RCV_READY: begin
						if (ev == EV_TX_DONE) begin
							res.radio_action = ACT_RX;
							res.duration_ms  = cfg.data_window_ms;
						end
					end
					PH_RCV_DATA: begin
						if (ev == EV_RX_DONE && ptype == {6'd0, PK_DATA}) begin
							res.radio_action = ACT_TX;
							res.duration_ms  = 16'd0;
							res.pkt_type     = PK_ACK;
							res.pkt_dest     = sender;
						end
					end
					PH_RCV_ACK: begin
						res.notice         = NOTE_RECV;
						res.notice_address = in_sender_q;
						res.notice_length  = in_len_q;
					end
					PH_SND_WAKE, PH_SND_DATA: begin
						if (ev == EV_TX_DONE) begin
							res.radio_action = ACT_RX;
							res.duration_ms  = cfg.short_window_ms;
						end else begin
							res.notice         = NOTE_FAIL;
							res.notice_address = pend_dest_q;
						end
					end
					PH_SND_READY: begin
						if (ev == EV_RX_DONE && sender == pend_dest_q) begin
							res.radio_action = ACT_TX;
							res.duration_ms  = 16'd0;
							res.pkt_type     = PK_DATA;
							res.pkt_dest     = pend_dest_q;
							res.pkt_length   = clip_len;
						end else if (tries_q < cfg.wake_retry_limit) begin
							res.radio_action = ACT_TX;
							res.duration_ms  = 16'd0;
							res.pkt_type     = PK_WAKE;
							res.pkt_dest     = pend_dest_q;
						end else begin
							res.notice         = NOTE_FAIL;
							res.notice_address = pend_dest_q;
						end
					end
					PH_SND_ACK: begin
						if (ev == EV_RX_DONE && sender == pend_dest_q &&
							ptype == {6'd0, PK_ACK}) begin
							res.notice         = NOTE_ACKED;
							res.notice_address = sender;
						end else begin
							res.notice         = NOTE_FAIL;
							res.notice_address = pend_dest_q;
						end
					end
					default: begin
						res.radio_action = ACT_RX;
						res.duration_ms  = cfg.wake_window_ms;
					end
				endcase
			end
			default: ;
		endcase
	end

	// State registers, updated once per processed word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_RCV_SLEEP;
			tries_q     <= 4'd0;
			pend_dest_q <= 8'd0;
			pend_len_q  <= 8'd0;
			in_sender_q <= 8'd0;
			in_len_q    <= 8'd0;
		end else if (fire) begin
			phase_q     <= phase_d;
			tries_q     <= tries_d;
			pend_dest_q <= pend_dest_d;
			pend_len_q  <= pend_len_d;
			in_sender_q <= in_sender_d;
			in_len_q    <= in_len_d;
		end
	end

endmodule

/* hdl/radio_wakeup_handshake_controller_core.sv */
// ----------------------------------------------------------------------------
// Radio wake-up handshake controller
// Duty-cycled link controller: wake, ready, data and acknowledge handshake.
// ----------------------------------------------------------------------------
// Usage:
// Each event word on evt (tx done, rx failed, rx done with header bytes,
// sleep done, send request, start) yields exactly one word on act: a radio
// command with its window or sleep time, the packet to transmit, an
// application notice and the link phase after the event.
// Configuration registers are written through cfg_we, cfg_index and
// cfg_wdata while no word is in flight.
// A word accepted on evt goes into the input register, then through the
// state logic into the output register, which drives it onto act. One
// word is accepted per cycle while act is not stalled; the state registers
// update together with the output register as each word moves on.
// When act is stalled the output register holds its word, the input register
// still takes one more word, and then evt.ready drops until act drains.
// Reset clears both registers' valid flags, puts the link into receiver
// sleep with no send pending, and loads the register defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module radio_wakeup_handshake_controller_core
	import rwhc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	rwhc_evt_if.sink              evt,
	rwhc_act_if.source            act,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	cfg_t    cfg_q;
	item_t   item_s1;
	logic    valid_s1;
	result_t res;
	result_t res_s2;
	logic    valid_s2;
	logic    advance;
	logic    fire;

	// The output register moves when empty or when its word is taken.
	assign advance   = !valid_s2 || act.ready;
	assign fire      = valid_s1 && advance;
	assign evt.ready = !valid_s1 || advance;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.own_address        <= RST_OWN_ADDRESS;
			cfg_q.bcast_address      <= RST_BCAST_ADDR;
			cfg_q.wake_window_ms     <= RST_WAKE_WINDOW;
			cfg_q.data_window_ms     <= RST_DATA_WINDOW;
			cfg_q.short_window_ms    <= RST_SHORT_WINDOW;
			cfg_q.nap_ms             <= RST_NAP;
			cfg_q.wake_retry_limit   <= RST_RETRY_LIMIT;
			cfg_q.max_message_length <= RST_MAX_LENGTH;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				REG_OWN_ADDRESS:  cfg_q.own_address        <= cfg_wdata[7:0];
				REG_BCAST_ADDR:   cfg_q.bcast_address      <= cfg_wdata[7:0];
				REG_WAKE_WINDOW:  cfg_q.wake_window_ms     <= cfg_wdata;
				REG_DATA_WINDOW:  cfg_q.data_window_ms     <= cfg_wdata;
				REG_SHORT_WINDOW: cfg_q.short_window_ms    <= cfg_wdata;
				REG_NAP:          cfg_q.nap_ms             <= cfg_wdata;
				REG_RETRY_LIMIT:  cfg_q.wake_retry_limit   <= cfg_wdata[3:0];
				REG_MAX_LENGTH:   cfg_q.max_message_length <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	// Input register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (evt.ready) begin
			valid_s1 <= evt.valid;
		end
	end

	// Input register payload.
	always_ff @(posedge clk) begin
		if (evt.valid && evt.ready) begin
			item_s1.cmd         <= evt.cmd;
			item_s1.rx_size     <= evt.rx_size;
			item_s1.rx_head0    <= evt.rx_head0;
			item_s1.rx_head1    <= evt.rx_head1;
			item_s1.rx_head2    <= evt.rx_head2;
			item_s1.req_address <= evt.req_address;
			item_s1.req_length  <= evt.req_length;
		end
	end

	rwhc_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.cfg    (cfg_q),
		.res    (res)
	);

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (fire) begin
			res_s2 <= res;
		end
	end

	assign act.valid          = valid_s2;
	assign act.radio_action   = res_s2.radio_action;
	assign act.duration_ms    = res_s2.duration_ms;
	assign act.pkt_type       = res_s2.pkt_type;
	assign act.pkt_dest       = res_s2.pkt_dest;
	assign act.pkt_length     = res_s2.pkt_length;
	assign act.notice         = res_s2.notice;
	assign act.notice_address = res_s2.notice_address;
	assign act.notice_length  = res_s2.notice_length;
	assign act.link_state     = res_s2.link_state;

endmodule

/* hdl/rwhc_checker.sv */
// ----------------------------------------------------------------------------
// Port checker for the handshake controller
// Concurrent checks on the top level's ports, bound to every instance.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "radio_wakeup_handshake_controller_core_defines.svh"

module rwhc_checker
	import rwhc_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        evt_valid,
	input logic        evt_ready,
	input logic        act_valid,
	input logic        act_ready,
	input logic [1:0]  act_radio_action,
	input logic [1:0]  act_pkt_type,
	input logic [7:0]  act_pkt_dest,
	input logic [7:0]  act_pkt_length,
	input logic [15:0] act_duration_ms,
	input logic [3:0]  act_link_state
);

	// A stalled result word stays valid and keeps its link state and duration.
	`RWHC_ASSERT_NEXT(a_act_hold, act_valid && !act_ready, act_valid && $stable(act_link_state) && $stable(act_duration_ms))

	// Only a stalled output can hold off the event channel.
	`RWHC_ASSERT_IMPL(a_evt_backpressure, !evt_ready, act_valid && !act_ready)

	// A word taken while act is empty leads, through the input and output registers, to a valid word on act.
	`RWHC_ASSERT_NEXT(a_latency, evt_valid && evt_ready && !act_valid, ##1 act_valid)

	// Packet fields are clear unless the word transmits.
	`RWHC_ASSERT_IMPL(a_pkt_clear, act_valid && act_radio_action != ACT_TX, act_pkt_type == PK_WAKE && act_pkt_dest == 8'd0 && act_pkt_length == 8'd0)

endmodule

bind radio_wakeup_handshake_controller_core rwhc_checker u_rwhc_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.evt_valid        (evt.valid),
	.evt_ready        (evt.ready),
	.act_valid        (act.valid),
	.act_ready        (act.ready),
	.act_radio_action (act.radio_action),
	.act_pkt_type     (act.pkt_type),
	.act_pkt_dest     (act.pkt_dest),
	.act_pkt_length   (act.pkt_length),
	.act_duration_ms  (act.duration_ms),
	.act_link_state   (act.link_state)
);
